/* rtl/core/waypoint_motion_stepper_core_macros.svh */
// Assertion macros for the waypoint motion stepper core.
// No dependencies; taken in by the top level.
`ifndef WAYPOINT_MOTION_STEPPER_CORE_MACROS_SVH
`define WAYPOINT_MOTION_STEPPER_CORE_MACROS_SVH
// condition implies property in the same cycle
`define WMS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// condition implies property in the next cycle
`define WMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* rtl/core/wms_pkg.sv */
// Package for the waypoint motion stepper: codes, constants, helpers.
// No dependencies.
package wms_pkg;
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_SET_TGT = 2'd1;
    localparam logic [1:0] OP_SET_POS = 2'd2;
    localparam logic [1:0] OP_SET_MOD = 2'd3;

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_MOVING  = 3'd1;
    localparam logic [2:0] MODE_CARRY   = 3'd3;
    localparam logic [2:0] MODE_ARRIVED = 3'd5;

    localparam logic [1:0] CFG_SPEED = 2'd0;
    localparam logic [1:0] CFG_TURN  = 2'd1;
    localparam logic [1:0] CFG_REACH = 2'd2;

    localparam int HALF_TURN = 23040;
    localparam int FULL_TURN = 46080;
    localparam logic [29:0] GAIN_Q30 = 30'd652032874;
    localparam int CW = 32;   // CORDIC x/y width
    localparam int ZW = 26;   // CORDIC angle width
    localparam int DW = 31;   // distance width
    localparam int QW = 25;   // quotient width
    localparam int NW = 50;   // dividend width

    function automatic logic [20:0] wms_atan(input logic [4:0] i);
        logic [20:0] v;
        case (i)
            5'd0: v = 21'd1474560;  5'd1: v = 21'd870484;
            5'd2: v = 21'd459940;   5'd3: v = 21'd233473;
            5'd4: v = 21'd117189;   5'd5: v = 21'd58652;
            5'd6: v = 21'd29333;    5'd7: v = 21'd14667;
            5'd8: v = 21'd7334;     5'd9: v = 21'd3667;
            5'd10: v = 21'd1833;    5'd11: v = 21'd917;
            5'd12: v = 21'd458;     5'd13: v = 21'd229;
            5'd14: v = 21'd115;     5'd15: v = 21'd57;
            5'd16: v = 21'd29;      5'd17: v = 21'd14;
            5'd18: v = 21'd7;       5'd19: v = 21'd4;
            5'd20: v = 21'd2;       5'd21: v = 21'd1;
            default: v = 21'd0;
        endcase
        return v;
    endfunction

    // one-turn wrap to +-180 degrees
    function automatic logic signed [15:0] wms_wrap(input logic signed [19:0] a);
        logic signed [19:0] r;
        r = a;
        if (a > 20'sd23040) begin
            r = a - 20'sd46080;
        end else if (a < -20'sd23040) begin
            r = a + 20'sd46080;
        end
        return r[15:0];
    endfunction
endpackage

/* rtl/core/wms_mul.sv */
// Shared registered multiplier, 32 x 32 unsigned.
// No dependencies.
module wms_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);
    logic [63:0] r_p;
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end
    assign o_p = r_p;
endmodule

/* rtl/core/wms_cordic.sv */
// Iterative CORDIC vectoring unit, one micro-rotation per cycle.
// Depends on wms_pkg.
module wms_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [24:0]         i_dx,
    input  logic signed [24:0]         i_dy,
    output logic                       o_done,
    output logic signed [wms_pkg::CW-1:0] o_x,
    output logic signed [wms_pkg::ZW-1:0] o_z
);
    import wms_pkg::*;
    localparam int IW = $clog2(CORDIC_STEPS);

    logic signed [CW-1:0] r_x, r_y, n_x, n_y, x0, y0, sx, sy;
    logic signed [ZW-1:0] r_z, n_z, at;
    logic [IW-1:0] r_i;
    logic r_busy, r_done;

    assign x0 = CW'(i_dx) <<< 4;
    assign y0 = CW'(i_dy) <<< 4;
    assign sx = r_x >>> r_i;
    assign sy = r_y >>> r_i;
    assign at = ZW'(wms_atan(5'(r_i)));

    always_comb begin
        if (r_y > 0) begin
            n_x = r_x + sy;
            n_y = r_y - sx;
            n_z = r_z + at;
        end else begin
            n_x = r_x - sy;
            n_y = r_y + sx;
            n_z = r_z - at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                if (x0 < 0) begin
                    r_x <= -x0;
                    r_y <= -y0;
                    r_z <= (y0 >= 0) ? ZW'(HALF_TURN * 256) : -ZW'(HALF_TURN * 256);
                end else begin
                    r_x <= x0;
                    r_y <= y0;
                    r_z <= '0;
                end
            end else if (r_busy) begin
                r_x <= n_x;
                r_y <= n_y;
                r_z <= n_z;
                r_i <= r_i + IW'(1);
                if (r_i == IW'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_z    = r_z;
endmodule

/* rtl/core/wms_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on wms_pkg.
module wms_div (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [wms_pkg::NW-1:0] i_num,
    input  logic [wms_pkg::DW-1:0] i_den,
    output logic                   o_done,
    output logic [wms_pkg::QW-1:0] o_quo
);
    import wms_pkg::*;
    localparam int CNW = $clog2(QW);

    logic [DW-1:0] r_rem, r_den;
    logic [QW-1:0] r_num;
    logic [DW:0]   t;
    logic [CNW-1:0] r_cnt;
    logic r_busy, r_done, qb;

    assign t  = {r_rem, r_num[QW-1]};
    assign qb = (t >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= DW'(i_num[NW-1:QW]);
                r_num  <= i_num[QW-1:0];
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= qb ? DW'(t - {1'b0, r_den}) : DW'(t);
                r_num <= {r_num[QW-2:0], qb};
                r_cnt <= r_cnt + CNW'(1);
                if (r_cnt == CNW'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;
endmodule

/* rtl/core/waypoint_motion_stepper_core.sv */
// Waypoint motion stepper core: sequencer, state and result register.
// Depends on wms_pkg, wms_mul, wms_cordic, wms_div and the macros header.
//
// channel  dir  handshake               contents
// s_axis   in   s_axis_tvalid/tready    tuser op; tdata coord_x, coord_y, tick_time, new_mode
// m_axis   out  m_axis_tvalid/tready    tdata pos_x, pos_y, heading, mode
// cfg      in   i_cfg_valid/o_cfg_ready index, data
//
// A moving tick runs the CORDIC pass and, unless it arrives first, two 25-bit serial
// divisions; set target runs the CORDIC pass alone; other requests go straight to
// the result. Synchronous active-low reset clears mode, state and handshakes. A
// stalled result holds the sequencer in its final step; one request at a time.
`include "waypoint_motion_stepper_core_macros.svh"
module waypoint_motion_stepper_core #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // coord_x, coord_y, tick_time, new_mode, zero pad
    input  logic [1:0]  s_axis_tuser,   // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // pos_x, pos_y, heading, mode, zero pad
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [22:0] i_cfg_data
);
    import wms_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001, S_VEC = 11'b00000000010, S_GAIN = 11'b00000000100,
        S_DIST = 11'b00000001000, S_TURN = 11'b00000010000, S_STEP = 11'b00000100000,
        S_SX   = 11'b00001000000, S_WX  = 11'b00010000000, S_SY   = 11'b00100000000,
        S_WY   = 11'b01000000000, S_FIN = 11'b10000000000
    } t_state;

    t_state r_state;
    logic [19:0] r_speed;
    logic [22:0] r_turn_rate;
    logic [15:0] r_reach;
    logic signed [23:0] r_pos_x, r_pos_y, r_tgt_x, r_tgt_y;
    logic signed [15:0] r_heading;
    logic [2:0]  r_mode;
    logic signed [24:0] r_dx, r_dy;
    logic [15:0] r_tick;
    logic        r_is_tgt;
    logic [DW-1:0] r_dist;
    logic [23:0] r_step;
    logic        r_ovalid;
    logic [71:0] r_odata;

    logic s_acc;
    logic [1:0] op;
    logic signed [23:0] cx, cy;
    logic [2:0] nm;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p, gsum;
    logic cor_start, cor_done, div_start, div_done;
    logic signed [CW-1:0] cor_x;
    logic signed [ZW-1:0] cor_z, zr;
    logic [DW-1:0] dist_now;
    logic signed [15:0] bearing, diff;
    logic [22:0] turn_now;
    logic [15:0] adiff;
    logic signed [24:0] h2;
    logic [23:0] step_now, adx, ady;
    logic [QW-1:0] quo;
    logic [NW-1:0] div_num;

    assign op = s_axis_tuser;
    assign cx = s_axis_tdata[23:0];
    assign cy = s_axis_tdata[47:24];
    assign nm = s_axis_tdata[66:64];
    assign s_axis_tready = (r_state == S_IDLE);
    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;

    assign adx = r_dx[24] ? 24'(-r_dx) : 24'(r_dx);
    assign ady = r_dy[24] ? 24'(-r_dy) : 24'(r_dy);

    always_comb begin
        case (r_state)
            S_GAIN:  begin mul_a = cor_x[CW-1] ? '0 : 32'(cor_x); mul_b = 32'(GAIN_Q30); end
            S_DIST:  begin mul_a = 32'(r_turn_rate); mul_b = 32'(r_tick); end
            S_TURN:  begin mul_a = 32'(r_speed);     mul_b = 32'(r_tick); end
            S_STEP:  begin mul_a = 32'(adx);         mul_b = 32'(step_now); end
            default: begin mul_a = 32'(ady);         mul_b = 32'(r_step); end
        endcase
    end

    wms_mul u_mul (.i_clk(i_clk), .i_a(mul_a), .i_b(mul_b), .o_p(mul_p));

    assign cor_start = (r_state == S_IDLE) && s_acc && (op == OP_SET_TGT ||
        (op == OP_TICK && (r_mode == MODE_MOVING || r_mode == MODE_CARRY)));

    wms_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(cor_start),
        .i_dx((op == OP_SET_TGT ? 25'(cx) : 25'(r_tgt_x)) - 25'(r_pos_x)),
        .i_dy((op == OP_SET_TGT ? 25'(cy) : 25'(r_tgt_y)) - 25'(r_pos_y)),
        .o_done(cor_done), .o_x(cor_x), .o_z(cor_z)
    );

    assign gsum     = mul_p + 64'(32'h2000_0000);
    assign dist_now = gsum[DW+29:30];
    assign zr       = cor_z + ZW'(128);
    assign bearing  = wms_wrap(20'(zr >>> 8));
    assign diff     = wms_wrap(20'(bearing) - 20'(r_heading));
    assign adiff    = diff[15] ? 16'(-diff) : 16'(diff);
    assign turn_now = mul_p[38:16];
    assign h2       = (diff > 0) ? 25'(r_heading) + 25'(turn_now)
                                 : 25'(r_heading) - 25'(turn_now);
    assign step_now = mul_p[35:12];

    assign div_start = (r_state == S_SX) || (r_state == S_SY);
    assign div_num   = mul_p[NW-1:0] + NW'(r_dist >> 1);

    wms_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(div_num), .i_den(r_dist), .o_done(div_done), .o_quo(quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_speed     <= '0;
            r_turn_rate <= '0;
            r_reach     <= 16'd512;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_tgt_x     <= '0;
            r_tgt_y     <= '0;
            r_heading   <= '0;
            r_mode      <= MODE_IDLE;
            r_ovalid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SPEED: r_speed     <= i_cfg_data[19:0];
                    CFG_TURN:  r_turn_rate <= i_cfg_data;
                    CFG_REACH: r_reach     <= i_cfg_data[15:0];
                    default:   ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready && r_state != S_FIN) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_tick   <= s_axis_tdata[63:48];
                        r_is_tgt <= (op == OP_SET_TGT);
                        r_dx     <= (op == OP_SET_TGT ? 25'(cx) : 25'(r_tgt_x)) - 25'(r_pos_x);
                        r_dy     <= (op == OP_SET_TGT ? 25'(cy) : 25'(r_tgt_y)) - 25'(r_pos_y);
                        r_state  <= cor_start ? S_VEC : S_FIN;
                        case (op)
                            OP_SET_TGT: begin r_tgt_x <= cx; r_tgt_y <= cy; end
                            OP_SET_POS: begin r_pos_x <= cx; r_pos_y <= cy; end
                            OP_SET_MOD: if (nm <= MODE_ARRIVED) r_mode <= nm;
                            default: ;
                        endcase
                    end
                end
                S_VEC:  if (cor_done) r_state <= S_GAIN;
                S_GAIN: r_state <= S_DIST;
                S_DIST: begin
                    r_dist <= dist_now;
                    if (dist_now <= DW'({r_reach, 4'd0})) begin
                        if (!r_is_tgt) begin
                            r_pos_x <= r_tgt_x;
                            r_pos_y <= r_tgt_y;
                        end
                        if (r_is_tgt || r_mode != MODE_CARRY) r_mode <= MODE_ARRIVED;
                        r_state <= S_FIN;
                    end else if (r_is_tgt) begin
                        if (r_mode != MODE_CARRY) r_mode <= MODE_MOVING;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_TURN;
                    end
                end
                S_TURN: begin
                    if (23'(adiff) <= turn_now) r_heading <= bearing;
                    else r_heading <= wms_wrap(20'(h2));
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    r_step <= step_now;
                    if (DW'(step_now) >= r_dist) begin
                        r_pos_x <= r_tgt_x;
                        r_pos_y <= r_tgt_y;
                        if (r_mode != MODE_CARRY) r_mode <= MODE_ARRIVED;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_SX;
                    end
                end
                S_SX: r_state <= S_WX;
                S_WX: if (div_done) begin
                    r_pos_x <= r_dx[24] ? r_pos_x - 24'(quo) : r_pos_x + 24'(quo);
                    r_state <= S_SY;
                end
                S_SY: r_state <= S_WY;
                S_WY: if (div_done) begin
                    r_pos_y <= r_dy[24] ? r_pos_y - 24'(quo) : r_pos_y + 24'(quo);
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {5'd0, r_mode, r_heading, r_pos_y, r_pos_x};
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    `WMS_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, s_acc, !s_axis_tready)
    `WMS_ASSERT_NOW(a_heading_range, i_clk, i_rst_n, 1'b1,
        r_heading <= 16'sd23040 && r_heading >= -16'sd23040)
    `WMS_ASSERT_NOW(a_mode_code, i_clk, i_rst_n, 1'b1, r_mode <= MODE_ARRIVED)
    `WMS_ASSERT_NOW(a_div_only_moving, i_clk, i_rst_n, div_start,
        r_mode == MODE_MOVING || r_mode == MODE_CARRY)
endmodule
